// ===== hw/rtl/fas_pkg.sv =====
`default_nettype none

package fas_pkg;

    // Field widths of one request and one response transaction.
    localparam int REQ_W   = 3;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;
    localparam int MASK_W  = 64;

    // The board is always held as two 64-bit words, bits 0..127.
    localparam int BOARD_W = 2 * MASK_W;

    // Default board size in fragments.
    localparam int FRAGMENT_SLOTS_DEFAULT = 128;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR       = 3'd0,
        REQ_SET_BIT     = 3'd1,
        REQ_CLEAR_BIT   = 3'd2,
        REQ_OR_MASK     = 3'd3,
        REQ_REMOVE_MASK = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [INDEX_W-1:0] fragment_index;
        logic [COUNT_W-1:0] fragment_count;
        logic [MASK_W-1:0]  mask_low;
        logic [MASK_W-1:0]  mask_high;
    } fas_req_t;

    typedef struct packed {
        logic               bit_is_set;
        logic               board_empty;
        logic               all_acked;
        logic [COUNT_W-1:0] acked_count;
        logic [COUNT_W-1:0] missing_count;
    } fas_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fas_if.sv =====
`default_nettype none

// Request channel.
interface fas_req_if
    import fas_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] fragment_index;
    logic [COUNT_W-1:0] fragment_count;
    logic [MASK_W-1:0]  mask_low;
    logic [MASK_W-1:0]  mask_high;

    modport source (
        output valid, req_type, fragment_index, fragment_count, mask_low, mask_high,
        input  ready
    );

    modport sink (
        input  valid, req_type, fragment_index, fragment_count, mask_low, mask_high,
        output ready
    );
endinterface

// Response channel.
interface fas_rsp_if
    import fas_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               bit_is_set;
    logic               board_empty;
    logic               all_acked;
    logic [COUNT_W-1:0] acked_count;
    logic [COUNT_W-1:0] missing_count;

    modport source (
        output valid, bit_is_set, board_empty, all_acked, acked_count, missing_count,
        input  ready
    );

    modport sink (
        input  valid, bit_is_set, board_empty, all_acked, acked_count, missing_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/fas_board.sv =====
`default_nettype none

// Holds the acknowledgement board and applies one request to it.
module fas_board
    import fas_pkg::*;
#(
    parameter int FRAGMENT_SLOTS = FRAGMENT_SLOTS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire fas_req_t           req,
    output logic [BOARD_W-1:0]      board_next
);

    localparam logic [COUNT_W-1:0] SLOTS_C   = COUNT_W'(FRAGMENT_SLOTS);
    localparam logic [BOARD_W-1:0] SLOT_MASK =
        (BOARD_W'(1) << FRAGMENT_SLOTS) - BOARD_W'(1);

    logic [BOARD_W-1:0] board_reg;
    logic [BOARD_W-1:0] bit_sel;
    logic [BOARD_W-1:0] mask_full;
    logic [BOARD_W-1:0] updated;
    logic               idx_ok;

    always_comb
    begin
        idx_ok    = {1'b0, req.fragment_index} < SLOTS_C;
        bit_sel   = idx_ok ? (BOARD_W'(1) << req.fragment_index) : '0;
        mask_full = {req.mask_high, req.mask_low};
        case (req.req_type)
            REQ_CLEAR:       updated = '0;
            REQ_SET_BIT:     updated = board_reg | bit_sel;
            REQ_CLEAR_BIT:   updated = board_reg & ~bit_sel;
            REQ_OR_MASK:     updated = board_reg | mask_full;
            REQ_REMOVE_MASK: updated = board_reg & ~mask_full;
            default:         updated = board_reg;
        endcase
        // Bits beyond the board size never enter the board.
        board_next = updated & SLOT_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= '0;
        end
        else if (advance)
        begin
            board_reg <= board_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fas_stats.sv =====
`default_nettype none

// Derives the response fields from the updated board.
module fas_stats
    import fas_pkg::*;
#(
    parameter int FRAGMENT_SLOTS = FRAGMENT_SLOTS_DEFAULT
)
(
    input  wire logic [BOARD_W-1:0] board,
    input  wire logic [INDEX_W-1:0] fragment_index,
    input  wire logic [COUNT_W-1:0] fragment_count,
    output fas_rsp_t                rsp
);

    localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(FRAGMENT_SLOTS);
    localparam int BYTES = BOARD_W / 8;

    logic [COUNT_W-1:0] n;
    logic [BOARD_W-1:0] count_mask;
    logic [BOARD_W-1:0] masked;
    logic [3:0]         cnt_l1 [BYTES];
    logic [4:0]         cnt_l2 [BYTES/2];
    logic [5:0]         cnt_l3 [BYTES/4];
    logic [6:0]         cnt_l4 [BYTES/8];
    logic [COUNT_W-1:0] acked;

    always_comb
    begin
        n          = (fragment_count < SLOTS_C) ? fragment_count : SLOTS_C;
        count_mask = (BOARD_W'(1) << n) - BOARD_W'(1);
        masked     = board & count_mask;

        // Population count as an adder tree: bytes, then pairwise sums.
        for (int b = 0; b < BYTES; b++)
        begin
            cnt_l1[b] = '0;
            for (int k = 0; k < 8; k++)
            begin
                cnt_l1[b] = cnt_l1[b] + 4'(masked[b*8 + k]);
            end
        end
        for (int b = 0; b < BYTES/2; b++)
        begin
            cnt_l2[b] = 5'(cnt_l1[2*b]) + 5'(cnt_l1[2*b + 1]);
        end
        for (int b = 0; b < BYTES/4; b++)
        begin
            cnt_l3[b] = 6'(cnt_l2[2*b]) + 6'(cnt_l2[2*b + 1]);
        end
        for (int b = 0; b < BYTES/8; b++)
        begin
            cnt_l4[b] = 7'(cnt_l3[2*b]) + 7'(cnt_l3[2*b + 1]);
        end
        acked = COUNT_W'(cnt_l4[0]) + COUNT_W'(cnt_l4[1]);

        rsp.bit_is_set    = ({1'b0, fragment_index} < SLOTS_C) && board[fragment_index];
        rsp.board_empty   = (board == '0);
        rsp.all_acked     = (fragment_count < SLOTS_C) && (masked == count_mask);
        rsp.acked_count   = acked;
        rsp.missing_count = n - acked;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fragment_ack_scoreboard.sv =====
`default_nettype none

// Fragment acknowledgement scoreboard.
// A request transaction on req may clear the 128-bit board, set or clear one
// fragment bit, OR in a 128-bit mask or remove one. Unused request codes
// leave the board alone. Every request yields exactly one response
// transaction on rsp that describes the board after the update: the indexed
// bit, whether the board is empty, whether all fragments below a
// fragment_count under the board size are acknowledged, and the
// acknowledged and missing counts. A request is taken into an input
// register; once the output register is free or being emptied, the board
// update and the masked population count run in one pass and the result is
// written into the output register. One request per cycle is sustained
// while the receiver keeps rsp.ready high, since each request sees the
// board left by the one before it.
// When the receiver stalls, the response holds in the output register and
// the input register still accepts one more request; only then does
// req.ready drop. Reset clears the board and both valid flags; no reset
// clearing pass is needed and requests are accepted right after reset.
module fragment_ack_scoreboard
    import fas_pkg::*;
#(
    parameter int FRAGMENT_SLOTS = FRAGMENT_SLOTS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    fas_req_if.sink   req,
    fas_rsp_if.source rsp
);

    logic               in_vld_reg;
    logic               in_vld_next;
    fas_req_t           in_data_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    fas_rsp_t           out_data_reg;
    logic               accept;
    logic               advance;
    logic [BOARD_W-1:0] board_next;
    fas_rsp_t           result;
    fas_req_t           req_data;

    // The held request moves on whenever the output register is free or
    // is being emptied in this same cycle.
    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign accept    = req.valid && req.ready;

    assign req_data.req_type       = req.req_type;
    assign req_data.fragment_index = req.fragment_index;
    assign req_data.fragment_count = req.fragment_count;
    assign req_data.mask_low       = req.mask_low;
    assign req_data.mask_high      = req.mask_high;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= req_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    fas_board #(
        .FRAGMENT_SLOTS (FRAGMENT_SLOTS)
    ) u_board (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .req        (in_data_reg),
        .board_next (board_next)
    );

    fas_stats #(
        .FRAGMENT_SLOTS (FRAGMENT_SLOTS)
    ) u_stats (
        .board          (board_next),
        .fragment_index (in_data_reg.fragment_index),
        .fragment_count (in_data_reg.fragment_count),
        .rsp            (result)
    );

    assign rsp.valid         = out_vld_reg;
    assign rsp.bit_is_set    = out_data_reg.bit_is_set;
    assign rsp.board_empty   = out_data_reg.board_empty;
    assign rsp.all_acked     = out_data_reg.all_acked;
    assign rsp.acked_count   = out_data_reg.acked_count;
    assign rsp.missing_count = out_data_reg.missing_count;

endmodule

`default_nettype wire

// ===== hw/rtl/fas_checker.sv =====
`default_nettype none

// Port-level checks for the scoreboard.
module fas_checker
    import fas_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               bit_is_set,
    input wire logic               board_empty,
    input wire logic               all_acked,
    input wire logic [COUNT_W-1:0] acked_count,
    input wire logic [COUNT_W-1:0] missing_count
);

    // A stalled response stays valid and keeps its counts and all_acked flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(acked_count)
            && $stable(missing_count) && $stable(all_acked))
        else $error("stalled response changed");

    // A response only starts after an accepted request has passed the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a matching request");

    // A fully acknowledged range has nothing missing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && all_acked |-> missing_count == '0)
        else $error("all_acked with missing fragments");

    // An empty board has no set bits to report.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && board_empty |-> acked_count == '0 && !bit_is_set)
        else $error("empty board reports set bits");

endmodule

bind fragment_ack_scoreboard fas_checker u_fas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .bit_is_set    (rsp.bit_is_set),
    .board_empty   (rsp.board_empty),
    .all_acked     (rsp.all_acked),
    .acked_count   (rsp.acked_count),
    .missing_count (rsp.missing_count)
);

`default_nettype wire

// ===== verif/tb_fragment_ack_scoreboard.sv =====
`default_nettype none

// Self-checking bench for the fragment acknowledgement scoreboard.
module tb_fragment_ack_scoreboard;
    import fas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its full board size of 128 fragments.
    localparam int SLOTS = FRAGMENT_SLOTS_DEFAULT;

    // Request codes 5 to 7 are not assigned and must leave the board alone.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    // Least number of random request transactions after the directed tests.
    localparam int RANDOM_REQUESTS = 1300;

    // Generous watchdog: roughly ten times the slowest legal run.
    localparam int CYCLE_LIMIT = 600000;

    // Extra cycles watched at the end for any unexpected response.
    localparam int DRAIN_CYCLES = 8;

    localparam logic [MASK_W-1:0] ALL_ONES = {MASK_W{1'b1}};

    logic clk;
    logic rst_n;

    fas_req_if req_ch ();
    fas_rsp_if rsp_ch ();

    fragment_ack_scoreboard #(
        .FRAGMENT_SLOTS (SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // The bench keeps its own copy of the board, updated at the moment each
    // request transaction is accepted, in the same order as the block sees them.
    logic [BOARD_W-1:0] acked_frags;

    // Responses that the board copy predicts, oldest first.
    fas_rsp_t board_reports[$];

    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned cycle_count;

    // When a side's idling is off it never waits; this gives stretches of
    // back-to-back traffic between the stretches with random gaps.
    bit tx_idle_on;
    bit rx_idle_on;

    // Cycles the response side still holds ready low before the next response.
    int unsigned rx_stall;

    always #5 clk = ~clk;

    // Bits below position n of the board, all of them once n reaches 128.
    function automatic logic [BOARD_W-1:0] low_bits(input int unsigned n);
        if (n == 0)
            return '0;
        if (n >= BOARD_W)
            return '1;
        return (BOARD_W'(1) << n) - BOARD_W'(1);
    endfunction

    // Applies one request to the board copy and returns the response that the
    // block must report on the board as it stands after the update.
    function automatic fas_rsp_t update_board(input fas_req_t r);
        fas_rsp_t     e;
        int unsigned  window_len;
        int unsigned  acked;
        logic [BOARD_W-1:0] window;
        logic               idx_on_board;

        idx_on_board = (int'(r.fragment_index) < SLOTS);
        case (r.req_type)
            REQ_CLEAR:       acked_frags = '0;
            REQ_SET_BIT:     if (idx_on_board) acked_frags[r.fragment_index] = 1'b1;
            REQ_CLEAR_BIT:   if (idx_on_board) acked_frags[r.fragment_index] = 1'b0;
            REQ_OR_MASK:     acked_frags = acked_frags | {r.mask_high, r.mask_low};
            REQ_REMOVE_MASK: acked_frags = acked_frags & ~{r.mask_high, r.mask_low};
            default:         ;
        endcase
        // Mask bits above the board size never reach the board.
        acked_frags = acked_frags & low_bits(SLOTS);

        // Counts saturate at the board size; the all-set test does not.
        window_len = (int'(r.fragment_count) < SLOTS) ? r.fragment_count : SLOTS;
        window     = low_bits(window_len);
        acked      = $countones(acked_frags & window);

        e.bit_is_set    = idx_on_board && acked_frags[r.fragment_index];
        e.board_empty   = (acked_frags == '0);
        e.all_acked     = (int'(r.fragment_count) < SLOTS) &&
                          ((acked_frags & window) == window);
        e.acked_count   = COUNT_W'(acked);
        e.missing_count = COUNT_W'(window_len - acked);
        return e;
    endfunction

    function automatic int unsigned draw_gap(input bit idle_on);
        if (!idle_on)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Drives one request transaction, waits until it is accepted, records the
    // predicted response, then idles for a random number of cycles. It is
    // always entered and left at a rising clock edge.
    task automatic send_request(input logic [REQ_W-1:0]   code,
                                input logic [INDEX_W-1:0] idx,
                                input logic [COUNT_W-1:0] cnt,
                                input logic [MASK_W-1:0]  lo,
                                input logic [MASK_W-1:0]  hi);
        fas_req_t    r;
        int unsigned gap;

        r.req_type       = code;
        r.fragment_index = idx;
        r.fragment_count = cnt;
        r.mask_low       = lo;
        r.mask_high      = hi;

        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= code;
        req_ch.fragment_index <= idx;
        req_ch.fragment_count <= cnt;
        req_ch.mask_low       <= lo;
        req_ch.mask_high      <= hi;

        // The transaction is taken at the first edge that sees ready high.
        do
            @(posedge clk);
        while (!req_ch.ready);

        board_reports.push_back(update_board(r));
        requests_sent++;

        gap = draw_gap(tx_idle_on);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A status query that changes nothing: an unused request code.
    task automatic query_board(input logic [INDEX_W-1:0] idx,
                               input logic [COUNT_W-1:0] cnt);
        send_request(REQ_UNUSED_LO, idx, cnt, ALL_ONES, ALL_ONES);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Response side: compares each accepted response with the oldest
    // prediction and holds ready low for a random number of cycles between
    // responses. Signals are sampled as they stood just before the edge.
    always @(posedge clk)
    begin
        fas_rsp_t e;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (board_reports.size() == 0)
            begin
                $display("%0t ns: response with none expected, actual %0d/%0d/%0d/%0d/%0d",
                         $time, rsp_ch.bit_is_set, rsp_ch.board_empty,
                         rsp_ch.all_acked, rsp_ch.acked_count, rsp_ch.missing_count);
                error_count++;
            end
            else
            begin
                e = board_reports.pop_front();
                check_field("bit_is_set", e.bit_is_set, rsp_ch.bit_is_set);
                check_field("board_empty", e.board_empty, rsp_ch.board_empty);
                check_field("all_acked", e.all_acked, rsp_ch.all_acked);
                check_field("acked_count", e.acked_count, rsp_ch.acked_count);
                check_field("missing_count", e.missing_count, rsp_ch.missing_count);
            end
            rx_stall = draw_gap(rx_idle_on);
        end

        if (rx_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a hang or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Queries on the board right after reset: zero count, the board size and
    // a count beyond it, each through a different unused request code.
    task automatic test_reset_state();
        send_request(REQ_UNUSED_LO, 7'd0, 8'd0, ALL_ONES, ALL_ONES);
        send_request(REQ_UNUSED_LO + 3'd1, 7'd127, 8'd128, ALL_ONES, '0);
        send_request(REQ_UNUSED_HI, 7'd64, 8'd255, '0, ALL_ONES);
    endtask

    // Single bits at both ends of each word, then clears in both words.
    task automatic test_single_bits();
        send_request(REQ_SET_BIT, 7'd0, 8'd1, '0, '0);
        send_request(REQ_SET_BIT, 7'd63, 8'd64, '0, '0);
        send_request(REQ_SET_BIT, 7'd64, 8'd65, '0, '0);
        send_request(REQ_SET_BIT, 7'd127, 8'd128, '0, '0);
        send_request(REQ_CLEAR_BIT, 7'd63, 8'd127, ALL_ONES, ALL_ONES);
        send_request(REQ_CLEAR_BIT, 7'd127, 8'd100, ALL_ONES, ALL_ONES);
        send_request(REQ_CLEAR_BIT, 7'd64, 8'd128, '0, '0);
    endtask

    // Whole-board masks. A full board is all-set for 127 fragments but, by
    // definition, never for a count of 128.
    task automatic test_masks();
        send_request(REQ_OR_MASK, 7'd5, 8'd127, ALL_ONES, ALL_ONES);
        query_board(7'd126, 8'd128);
        send_request(REQ_REMOVE_MASK, 7'd10, 8'd64, ALL_ONES, '0);
        send_request(REQ_OR_MASK, 7'd70, 8'd90, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_REMOVE_MASK, 7'd100, 8'd128, ALL_ONES, ALL_ONES);
    endtask

    // Fragment counts around the word boundary with the low word full and a
    // partly filled high word.
    task automatic test_count_edges();
        send_request(REQ_OR_MASK, 7'd64, 8'd63, ALL_ONES, 64'h0000_0000_0000_00FF);
        query_board(7'd0, 8'd64);
        query_board(7'd71, 8'd65);
        query_board(7'd72, 8'd72);
        query_board(7'd72, 8'd73);
        send_request(REQ_CLEAR, 7'd0, 8'd128, ALL_ONES, ALL_ONES);
    endtask

    function automatic logic [MASK_W-1:0] random_word();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} & {$urandom, $urandom};
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            default: return $urandom_range(0, 1) ? ALL_ONES : '0;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] REQ_CODE_UNUSED();
        return REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endfunction

    // Random traffic shaped like real frames: each frame starts with a clear,
    // then acknowledgements arrive mostly for fragments inside the frame and
    // are queried against the frame size. A minority of requests are masks,
    // stray indexes, unused codes and odd fragment counts.
    task automatic test_random_frames();
        int unsigned  start_count;
        int unsigned  frame_len;
        int unsigned  frame_top;
        int unsigned  ops;
        int unsigned  pick;
        logic [COUNT_W-1:0] cnt;
        logic [INDEX_W-1:0] idx;
        logic [BOARD_W-1:0] frame_mask;
        logic [BOARD_W-1:0] m;

        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS)
        begin
            // Vary idling per frame so both busy and idle stretches occur.
            pick       = $urandom_range(0, 3);
            tx_idle_on = (pick != 0);
            rx_idle_on = (pick != 1);

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: frame_len = $urandom_range(1, 24);
                6, 7:             frame_len = $urandom_range(25, 128);
                8:                frame_len = $urandom_range(0, 255);
                default:          frame_len = $urandom_range(120, 128);
            endcase
            frame_top  = (frame_len > SLOTS) ? SLOTS : frame_len;
            frame_mask = low_bits(frame_top);

            send_request(REQ_CLEAR, INDEX_W'($urandom), COUNT_W'(frame_len),
                         random_word(), random_word());

            ops = $urandom_range(4, 40);
            repeat (ops)
            begin
                cnt = ($urandom_range(0, 99) < 85) ? COUNT_W'(frame_len)
                                                   : COUNT_W'($urandom_range(0, 255));
                idx = (frame_top == 0) ? INDEX_W'($urandom)
                                       : INDEX_W'($urandom_range(0, frame_top - 1));
                m   = {random_word(), random_word()};
                if ($urandom_range(0, 9) < 7)
                    m = m & frame_mask;

                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_request(REQ_SET_BIT, idx, cnt, m[63:0], m[127:64]);
                else if (pick < 62)
                    send_request(REQ_CLEAR_BIT, idx, cnt, m[63:0], m[127:64]);
                else if (pick < 72)
                    send_request(REQ_OR_MASK, idx, cnt, m[63:0], m[127:64]);
                else if (pick < 80)
                    send_request(REQ_REMOVE_MASK, idx, cnt, m[63:0], m[127:64]);
                else if (pick < 87)
                    send_request(REQ_CODE_UNUSED(), idx, cnt, m[63:0], m[127:64]);
                else if (pick < 90)
                    send_request(REQ_CLEAR, idx, cnt, m[63:0], m[127:64]);
                else
                    send_request(REQ_SET_BIT, INDEX_W'($urandom), cnt,
                                 m[63:0], m[127:64]);
            end
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        error_count   = 0;
        requests_sent = 0;
        cycle_count   = 0;
        rx_stall      = 0;
        acked_frags   = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;

        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_CLEAR;
        req_ch.fragment_index = '0;
        req_ch.fragment_count = '0;
        req_ch.mask_low       = '0;
        req_ch.mask_high      = '0;
        rsp_ch.ready          = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_bits();
        test_masks();
        test_count_edges();
        test_random_frames();

        req_ch.valid <= 1'b0;

        // Wait for every predicted response, then watch a little longer for
        // any response that should not be there. The watchdog bounds this.
        while (board_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/fas_pkg.sv
hw/rtl/fas_if.sv
hw/rtl/fas_board.sv
hw/rtl/fas_stats.sv
hw/rtl/fragment_ack_scoreboard.sv
hw/rtl/fas_checker.sv
verif/tb_fragment_ack_scoreboard.sv
